>>> src/tsc_pkg.sv
package tsc_pkg;

    // Command codes carried in the input tuser field
    typedef enum logic [1:0] {
        CMD_PROCESS = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int REPORT_WIDTH    = 32;
    localparam int NUM_LETTERS     = 26;
    localparam int CHAR_WIDTH      = 8;
    localparam int LETTER_WIDTH    = 5;
    localparam int NUM_FIELDS_OUT  = 5;

    // Character codes
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_QUEST = 8'h3F;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_UP_A  = 8'd65;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_E  = 8'h65;
    localparam logic [7:0] CHAR_LO_I  = 8'h69;
    localparam logic [7:0] CHAR_LO_O  = 8'h6F;
    localparam logic [7:0] CHAR_LO_U  = 8'h75;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
    endfunction

    function automatic logic is_lower_vowel(input logic [7:0] c);
        return (c == CHAR_LO_A) || (c == CHAR_LO_E) || (c == CHAR_LO_I) ||
               (c == CHAR_LO_O) || (c == CHAR_LO_U);
    endfunction

    // Clamp a count (zero-extended to 64 bits) to the 32-bit report range
    function automatic logic [REPORT_WIDTH-1:0] report(input logic [63:0] c);
        return (|c[63:REPORT_WIDTH]) ? '1 : c[REPORT_WIDTH-1:0];
    endfunction

endpackage

>>> src/text_statistics_counter.sv
// An input beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle unless the output stalls; each byte needs only flag decode
// and one saturating increment per counter, all between the input and result registers.
// Reset (i_rst_n low, synchronous): counts cleared, paragraph count set to 1, token and
// line feed flags cleared, both pipeline stages emptied.
module text_statistics_counter
    import tsc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [7:0] char_code, [12:8] letter_index, rest zero
    input  logic [1:0]   s_axis_tuser,   // [1:0] command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata    // word, sentence, paragraph, vowel, letter counts
);

    localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c,
                                                       input logic en);
        return (en && (c != '1)) ? c + ONE : c;
    endfunction

    // Input stage
    logic                    r_in_valid;
    t_cmd                    r_in_cmd;
    logic [CHAR_WIDTH-1:0]   r_in_char;
    logic [LETTER_WIDTH-1:0] r_in_li;

    // Statistics state
    logic [COUNT_WIDTH-1:0]  r_words, r_sent, r_para, r_vowel;
    logic [COUNT_WIDTH-1:0]  r_first [NUM_LETTERS];
    logic                    r_nl_pend, r_in_tok, r_in_run;

    logic [COUNT_WIDTH-1:0]  n_words, n_sent, n_para, n_vowel;
    logic [COUNT_WIDTH-1:0]  n_first [NUM_LETTERS];
    logic                    n_nl_pend, n_in_tok, n_in_run;

    // Result stage
    logic                    r_out_valid;
    logic [159:0]            r_out_data;
    logic [159:0]            n_out_data;

    logic                    adv;

    // Pipeline control: the result register frees up whenever its beat is taken
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= t_cmd'(s_axis_tuser);
            r_in_char <= s_axis_tdata[7:0];
            r_in_li   <= s_axis_tdata[12:8];
        end
    end

    // Byte classification and next state
    always_comb begin
        logic                    inc_word, inc_sent, inc_para, inc_vowel, inc_letter;
        logic                    letter, outside;
        logic [CHAR_WIDTH-1:0]   low;
        logic [CHAR_WIDTH-1:0]   idx8;
        logic [LETTER_WIDTH-1:0] idx;

        inc_word   = 1'b0;
        inc_sent   = 1'b0;
        inc_para   = 1'b0;
        inc_vowel  = 1'b0;
        inc_letter = 1'b0;
        n_nl_pend  = r_nl_pend;
        n_in_tok   = r_in_tok;
        n_in_run   = r_in_run;
        letter     = is_lower(r_in_char) || is_upper(r_in_char);
        low        = is_upper(r_in_char) ? (r_in_char | CASE_BIT) : r_in_char;
        idx8       = low - CHAR_LO_A;
        idx        = idx8[LETTER_WIDTH-1:0];
        outside    = 1'b1;

        if (r_in_tok) begin
            if (!is_space(r_in_char)) begin
                outside  = 1'b0;
                inc_sent = (r_in_char == CHAR_DOT) || (r_in_char == CHAR_BANG) ||
                           (r_in_char == CHAR_QUEST);
                if (r_in_run) begin
                    if (letter) begin
                        inc_vowel = is_lower_vowel(r_in_char);
                    end else begin
                        n_in_run = 1'b0;
                    end
                end
            end else begin
                n_in_tok = 1'b0;
                n_in_run = 1'b0;
            end
        end

        if (outside) begin
            if (r_nl_pend) begin
                n_nl_pend = 1'b0;
                if (r_in_char == CHAR_LF) begin
                    inc_para = 1'b1;
                    outside  = 1'b0;
                end
            end else if (r_in_char == CHAR_LF) begin
                n_nl_pend = 1'b1;
                outside   = 1'b0;
            end
        end

        // Word start
        if (outside && letter) begin
            n_in_tok   = 1'b1;
            n_in_run   = 1'b1;
            inc_word   = 1'b1;
            inc_vowel  = is_lower_vowel(low);
            inc_letter = 1'b1;
        end

        n_words = r_words;
        n_sent  = r_sent;
        n_para  = r_para;
        n_vowel = r_vowel;
        for (int i = 0; i < NUM_LETTERS; i++) begin
            n_first[i] = r_first[i];
        end

        case (r_in_cmd)
            CMD_PROCESS: begin
                n_words = sat_inc(r_words, inc_word);
                n_sent  = sat_inc(r_sent, inc_sent);
                n_para  = sat_inc(r_para, inc_para);
                n_vowel = sat_inc(r_vowel, inc_vowel);
                for (int i = 0; i < NUM_LETTERS; i++) begin
                    n_first[i] = sat_inc(r_first[i],
                                         inc_letter && (idx == LETTER_WIDTH'(i)));
                end
            end
            CMD_CLEAR: begin
                n_words   = '0;
                n_sent    = '0;
                n_para    = ONE;
                n_vowel   = '0;
                n_nl_pend = 1'b0;
                n_in_tok  = 1'b0;
                n_in_run  = 1'b0;
                for (int i = 0; i < NUM_LETTERS; i++) begin
                    n_first[i] = '0;
                end
            end
            default: begin
                // query: state unchanged
                n_nl_pend = r_nl_pend;
                n_in_tok  = r_in_tok;
                n_in_run  = r_in_run;
            end
        endcase
    end

    // Result formatting from the updated state
    always_comb begin
        logic [REPORT_WIDTH-1:0] letter_rep;

        letter_rep = '0;
        for (int i = 0; i < NUM_LETTERS; i++) begin
            if (r_in_li == LETTER_WIDTH'(i)) begin
                letter_rep = report(64'(n_first[i]));
            end
        end
        n_out_data = {letter_rep,
                      report(64'(n_vowel)),
                      report(64'(n_para)),
                      report(64'(n_sent)),
                      report(64'(n_words))};
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words   <= '0;
            r_sent    <= '0;
            r_para    <= ONE;
            r_vowel   <= '0;
            r_nl_pend <= 1'b0;
            r_in_tok  <= 1'b0;
            r_in_run  <= 1'b0;
            for (int i = 0; i < NUM_LETTERS; i++) begin
                r_first[i] <= '0;
            end
        end else if (adv) begin
            r_words   <= n_words;
            r_sent    <= n_sent;
            r_para    <= n_para;
            r_vowel   <= n_vowel;
            r_nl_pend <= n_nl_pend;
            r_in_tok  <= n_in_tok;
            r_in_run  <= n_in_run;
            for (int i = 0; i < NUM_LETTERS; i++) begin
                r_first[i] <= n_first[i];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    // Checks
    a_run_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> r_in_tok)
        else $error("letter run flag set outside a token");

    a_pend_not_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_nl_pend && r_in_tok))
        else $error("line feed pending inside a token");

    a_para_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_para != '0)
        else $error("paragraph count dropped to zero");

    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ((r_words == $past(r_words)) || (r_words == $past(r_words) + ONE) ||
             (r_words == '0)))
        else $error("word count moved by more than one");

endmodule
